[rtl/sgs_pkg.sv]
// ----------------------------------------------------------------------------
// sgs_pkg
// Shared types, constants and the digit font of the seconds-to-digit glyph
// sequencer.
// ----------------------------------------------------------------------------
package sgs_pkg;

	// Input range and time unit constants.
	localparam logic [18:0] SECONDS_MAX      = 19'd359999;
	localparam logic [18:0] SECS_PER_HOUR    = 19'd3600;
	localparam logic [11:0] SECS_PER_MINUTE  = 12'd60;

	// Reciprocal multipliers: x / 3600 = (x * RECIP_HOUR) >> 31 for x < 2^19,
	// x / 60 = (x * RECIP_MINUTE) >> 18 for x < 3600,
	// x / 10 = (x * RECIP_TEN) >> 11 for x < 128.
	localparam logic [19:0] RECIP_HOUR       = 20'd596524;
	localparam logic [12:0] RECIP_MINUTE     = 13'd4370;
	localparam logic [7:0]  RECIP_TEN        = 8'd205;

	// Column placement.
	localparam logic [6:0]  BASE_COLUMN_RESET = 7'd85;
	localparam logic [6:0]  FIELD_STEP        = 7'd20;
	localparam logic [6:0]  TENS_OFFSET       = 7'd10;

	// Records per item and register map.
	localparam logic [2:0]  LAST_REC_IDX      = 3'd5;
	localparam logic        REG_BASE_COLUMN   = 1'b0;
	localparam int          QUEUE_DEPTH       = 2;

	// One classified item as it waits for the record emitter.
	typedef struct packed {
		logic [6:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
		logic [2:0] mask;
	} sgs_entry_t;

	// 8x8 font, byte k of the glyph in bits 8k+7:8k.
	function automatic logic [63:0] glyph_of(input logic [3:0] digit);
		logic [63:0] g;
		case (digit)
			4'd0:    g = 64'h003E7F45497F3E00;
			4'd1:    g = 64'h0000407F7F420000;
			4'd2:    g = 64'h00464F5971634200;
			4'd3:    g = 64'h00367F4949632200;
			4'd4:    g = 64'h00107F7F161C1800;
			4'd5:    g = 64'h00397D4545672700;
			4'd6:    g = 64'h003079494B7E3C00;
			4'd7:    g = 64'h0003070D79710100;
			4'd8:    g = 64'h00367F49497F3600;
			default: g = 64'h001E3F69494F0600;
		endcase
		return g;
	endfunction

endpackage

[rtl/sgs_front.sv]
// ----------------------------------------------------------------------------
// sgs_front
// Accepts items, saturates the count and splits it into hours, minutes and
// seconds over a four-stage pipeline.
// ----------------------------------------------------------------------------
module sgs_front import sgs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [18:0] elapsed_seconds,
	input  logic [2:0]  highlight_mask,
	input  logic        queue_full,
	output logic        push,
	output sgs_entry_t  entry
);

	logic        valid_s1, valid_s2, valid_s3, valid_s4;
	logic [18:0] secs_s1;
	logic [6:0]  hours_s1, hours_s2, hours_s3;
	logic [2:0]  mask_s1, mask_s2, mask_s3;
	logic [11:0] rem_s2, rem_s3;
	logic [5:0]  minutes_s3;
	sgs_entry_t  entry_s4;

	logic        advance;
	logic [18:0] secs_sat;
	logic [38:0] hour_prod;
	logic [18:0] rem_full;
	logic [24:0] minute_prod;
	logic [11:0] sec_full;

	// The whole pipeline holds only when its last stage cannot enter the queue.
	assign advance  = !(valid_s4 && queue_full);
	assign in_stall = !advance;
	assign push     = valid_s4 && !queue_full;
	assign entry    = entry_s4;

	// Stage 1: saturate and divide by 3600 through the reciprocal.
	assign secs_sat  = (elapsed_seconds > SECONDS_MAX) ? SECONDS_MAX : elapsed_seconds;
	assign hour_prod = {20'd0, secs_sat} * {19'd0, RECIP_HOUR};

	// Stage 2: remainder within the hour.
	assign rem_full = secs_s1 - ({12'd0, hours_s1} * SECS_PER_HOUR);

	// Stage 3: divide the remainder by 60.
	assign minute_prod = {13'd0, rem_s2} * {12'd0, RECIP_MINUTE};

	// Stage 4: seconds within the minute.
	assign sec_full = rem_s3 - ({6'd0, minutes_s3} * SECS_PER_MINUTE);

	// Valid bits of the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Payload of the stages.
	always_ff @(posedge clk) begin
		if (advance) begin
			secs_s1          <= secs_sat;
			hours_s1         <= hour_prod[37:31];
			mask_s1          <= highlight_mask;
			rem_s2           <= rem_full[11:0];
			hours_s2         <= hours_s1;
			mask_s2          <= mask_s1;
			minutes_s3       <= minute_prod[23:18];
			rem_s3           <= rem_s2;
			hours_s3         <= hours_s2;
			mask_s3          <= mask_s2;
			entry_s4.hours   <= hours_s3;
			entry_s4.minutes <= minutes_s3;
			entry_s4.seconds <= sec_full[5:0];
			entry_s4.mask    <= mask_s3;
		end
	end

endmodule

[rtl/sgs_queue.sv]
// ----------------------------------------------------------------------------
// sgs_queue
// Two-entry queue between the splitting pipeline and the record emitter.
// ----------------------------------------------------------------------------
module sgs_queue import sgs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  sgs_entry_t push_entry,
	input  logic       pop,
	output logic       full,
	output logic       head_valid,
	output sgs_entry_t head_entry
);

	sgs_entry_t  slots_q [QUEUE_DEPTH];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign full       = (count_q == 2'(QUEUE_DEPTH));
	assign head_valid = (count_q != 2'd0);
	assign head_entry = slots_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_ptr_q] <= push_entry;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue read while empty");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'(QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

[rtl/sgs_back.sv]
// ----------------------------------------------------------------------------
// sgs_back
// Record emitter: turns one queued item into six draw records, one per
// cycle while out_stall is low, through a registered output stage.
// ----------------------------------------------------------------------------
module sgs_back import sgs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [6:0]  base_column,
	input  logic        head_valid,
	input  sgs_entry_t  head_entry,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [6:0]  start_column,
	output logic [3:0]  digit_value,
	output logic [63:0] glyph_bytes,
	output logic        underline_on,
	output logic        last_record
);

	logic [2:0]  rec_idx_q;
	logic        out_valid_q;
	logic [6:0]  column_q;
	logic [3:0]  digit_q;
	logic [63:0] glyph_q;
	logic        underline_q;
	logic        last_q;

	logic        advance;
	logic [1:0]  field;
	logic [6:0]  part;
	logic [14:0] tens_prod;
	logic [3:0]  tens;
	logic [6:0]  units_full;
	logic [3:0]  digit;
	logic [6:0]  units_col;
	logic [6:0]  column;
	logic        underline;

	// A record moves into the output register when it is empty or being taken.
	assign advance = head_valid && (!out_valid_q || !out_stall);
	assign pop     = advance && (rec_idx_q == LAST_REC_IDX);

	// Select the field of this record: seconds, minutes, then hours.
	assign field = rec_idx_q[2:1];
	always_comb begin
		case (field)
			2'd0:    part = {1'b0, head_entry.seconds};
			2'd1:    part = {1'b0, head_entry.minutes};
			default: part = head_entry.hours;
		endcase
	end

	// Split the field into tens and units.
	assign tens_prod  = {8'd0, part} * {7'd0, RECIP_TEN};
	assign tens       = tens_prod[14:11];
	assign units_full = part - ({3'd0, tens} * TENS_OFFSET);
	assign digit      = rec_idx_q[0] ? units_full[3:0] : tens;

	// Columns wrap modulo 128; tens sit left of the units.
	assign units_col = base_column - (7'(field) * FIELD_STEP);
	assign column    = rec_idx_q[0] ? units_col : (units_col - TENS_OFFSET);
	assign underline = head_entry.mask[field];

	// Record index within the item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_idx_q   <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance)
				rec_idx_q <= (rec_idx_q == LAST_REC_IDX) ? 3'd0 : rec_idx_q + 3'd1;
			if (advance)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			column_q    <= column;
			digit_q     <= digit;
			glyph_q     <= glyph_of(digit);
			underline_q <= underline;
			last_q      <= (rec_idx_q == LAST_REC_IDX);
		end
	end

	assign out_valid    = out_valid_q;
	assign start_column = column_q;
	assign digit_value  = digit_q;
	assign glyph_bytes  = glyph_q;
	assign underline_on = underline_q;
	assign last_record  = last_q;

	a_wrap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && rec_idx_q == LAST_REC_IDX) |=> (rec_idx_q == 3'd0))
		else $error("record index did not wrap after the last record");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (digit_q <= 4'd9))
		else $error("digit out of range");

endmodule

[rtl/seconds_to_digit_glyph_sequencer.sv]
// ----------------------------------------------------------------------------
// seconds_to_digit_glyph_sequencer
// Turns a seconds count into six hh:mm:ss digit draw records.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall) takes one item per accepted cycle:
// a seconds count and a 3-bit highlight mask. Counts above 99:59:59 are
// shown as 99:59:59. Each item yields six records on the output channel
// (out_valid, out_stall) in the order seconds tens, seconds units, minutes
// tens, minutes units, hours tens, hours units; last_record marks the sixth.
// The first record passes through four split stages, the queue and the output
// register after the item is accepted. The record emitter produces one record
// per cycle while out_stall is low, so sustained throughput is set by the
// emitter; a two-entry queue lets the front keep accepting while the
// emitter works. When the receiver stalls, the output record holds and the
// emitter, then the queue and the split pipeline, fill up before in_stall
// rises. Reset empties all stages and sets base_column to 85. base_column is
// written through the APB port at byte address 0.
// ----------------------------------------------------------------------------
module seconds_to_digit_glyph_sequencer import sgs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Input channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [18:0] elapsed_seconds,
	input  logic [2:0]  highlight_mask,
	// Output channel.
	output logic        out_valid,
	input  logic        out_stall,
	output logic [6:0]  start_column,
	output logic [3:0]  digit_value,
	output logic [63:0] glyph_bytes,
	output logic        underline_on,
	output logic        last_record
);

	logic       [6:0] base_column_q;
	logic             reg_hit;
	logic             push;
	logic             pop;
	logic             queue_full;
	logic             head_valid;
	sgs_entry_t       push_entry;
	sgs_entry_t       head_entry;

	// Register file: a single register, decoded from paddr[2] alone, at byte addresses 0 to 3.
	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == REG_BASE_COLUMN);
	assign prdata  = reg_hit ? {25'd0, base_column_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			base_column_q <= BASE_COLUMN_RESET;
		else if (psel && penable && pwrite && pready && reg_hit)
			base_column_q <= pwdata[6:0];
	end

	// Front: accept and split the count.
	sgs_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.elapsed_seconds (elapsed_seconds),
		.highlight_mask  (highlight_mask),
		.queue_full      (queue_full),
		.push            (push),
		.entry           (push_entry)
	);

	// Queue between front and back.
	sgs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (queue_full),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	// Back: emit six records per item.
	sgs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.base_column  (base_column_q),
		.head_valid   (head_valid),
		.head_entry   (head_entry),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.start_column (start_column),
		.digit_value  (digit_value),
		.glyph_bytes  (glyph_bytes),
		.underline_on (underline_on),
		.last_record  (last_record)
	);

endmodule

[tb/tb_seconds_to_digit_glyph_sequencer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_seconds_to_digit_glyph_sequencer
// Self-checking bench for the seconds-to-digit glyph sequencer. Time items go
// in through a valid/stall driver fed from a queue. Every accepted item is
// expanded into its six digit draw records by a local predictor. A monitor
// compares each accepted record with the oldest predicted one. Both sides
// idle at random. The base column is changed over the APB port only while
// the block is drained.
// ----------------------------------------------------------------------------
module tb_seconds_to_digit_glyph_sequencer;
	import sgs_pkg::*;

	// APB byte addresses: the base column register and an unmapped slot.
	localparam logic [2:0] ADDR_BASE_COLUMN = 3'd0;
	localparam logic [2:0] ADDR_UNMAPPED    = 3'd4;
	localparam int         COUNT_LIMIT      = 359999;

	typedef struct packed {
		logic [18:0] secs;
		logic [2:0]  mask;
	} time_item_t;

	typedef struct packed {
		logic [6:0]  column;
		logic [3:0]  digit;
		logic [63:0] glyph;
		logic        underline;
		logic        last;
	} digit_record_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [18:0] elapsed_seconds = '0;
	logic [2:0]  highlight_mask = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [6:0]  start_column;
	logic [3:0]  digit_value;
	logic [63:0] glyph_bytes;
	logic        underline_on;
	logic        last_record;

	time_item_t    time_queue[$];
	digit_record_t pending_records[$];
	logic [6:0]    model_base = BASE_COLUMN_RESET;
	logic          no_gaps = 1'b0;
	int            err_count = 0;
	int            items_accepted = 0;
	int            records_checked = 0;
	int            settings_applied = 0;

	seconds_to_digit_glyph_sequencer u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.elapsed_seconds (elapsed_seconds),
		.highlight_mask  (highlight_mask),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.start_column    (start_column),
		.digit_value     (digit_value),
		.glyph_bytes     (glyph_bytes),
		.underline_on    (underline_on),
		.last_record     (last_record)
	);

	// Clock generation.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Font columns listed left to right, then repacked with column 0 in the low byte.
	function automatic logic [63:0] glyph_for_digit(input int digit);
		logic [63:0] cols;
		logic [63:0] g;
		int          k;
		case (digit)
			0:       cols = {8'h00, 8'h3E, 8'h7F, 8'h49, 8'h45, 8'h7F, 8'h3E, 8'h00};
			1:       cols = {8'h00, 8'h00, 8'h42, 8'h7F, 8'h7F, 8'h40, 8'h00, 8'h00};
			2:       cols = {8'h00, 8'h42, 8'h63, 8'h71, 8'h59, 8'h4F, 8'h46, 8'h00};
			3:       cols = {8'h00, 8'h22, 8'h63, 8'h49, 8'h49, 8'h7F, 8'h36, 8'h00};
			4:       cols = {8'h00, 8'h18, 8'h1C, 8'h16, 8'h7F, 8'h7F, 8'h10, 8'h00};
			5:       cols = {8'h00, 8'h27, 8'h67, 8'h45, 8'h45, 8'h7D, 8'h39, 8'h00};
			6:       cols = {8'h00, 8'h3C, 8'h7E, 8'h4B, 8'h49, 8'h79, 8'h30, 8'h00};
			7:       cols = {8'h00, 8'h01, 8'h71, 8'h79, 8'h0D, 8'h07, 8'h03, 8'h00};
			8:       cols = {8'h00, 8'h36, 8'h7F, 8'h49, 8'h49, 8'h7F, 8'h36, 8'h00};
			default: cols = {8'h00, 8'h06, 8'h4F, 8'h49, 8'h69, 8'h3F, 8'h1E, 8'h00};
		endcase
		for (k = 0; k < 8; k++) begin
			g[8*k +: 8] = cols[8*(7-k) +: 8];
		end
		return g;
	endfunction

	// Expand one time item into its six draw records: tens then units for
	// seconds, minutes and hours, each field 20 columns left of the last.
	task automatic queue_digit_records(input logic [18:0] secs, input logic [2:0] mask);
		int            count;
		int            field;
		int            part;
		int            units_col;
		int            tens_col;
		int            parts[3];
		digit_record_t rec;
		count = (secs > COUNT_LIMIT) ? COUNT_LIMIT : int'(secs);
		parts[0] = count % 60;
		parts[1] = (count / 60) % 60;
		parts[2] = count / 3600;
		for (field = 0; field < 3; field++) begin
			part = parts[field];
			units_col = int'(model_base) - 20 * field;
			tens_col = units_col - 10;
			rec.column = tens_col[6:0];
			rec.digit = 4'(part / 10);
			rec.glyph = glyph_for_digit(part / 10);
			rec.underline = mask[field];
			rec.last = 1'b0;
			pending_records.push_back(rec);
			rec.column = units_col[6:0];
			rec.digit = 4'(part % 10);
			rec.glyph = glyph_for_digit(part % 10);
			rec.last = (field == 2);
			pending_records.push_back(rec);
		end
	endtask

	// Pick 0, 9, 10, the top value or anything in range for a time field.
	function automatic int corner_value(input int top);
		case ($urandom_range(0, 4))
			0:       return 0;
			1:       return 9;
			2:       return 10;
			3:       return top;
			default: return $urandom_range(0, top);
		endcase
	endfunction

	// Mostly in-range counts, plus saturating counts, field corners and raw bits.
	function automatic time_item_t random_time();
		time_item_t item;
		int         sel;
		sel = $urandom_range(0, 99);
		if (sel < 55) begin
			item.secs = 19'($urandom_range(0, COUNT_LIMIT));
		end else if (sel < 70) begin
			item.secs = 19'($urandom_range(COUNT_LIMIT, 524287));
		end else if (sel < 90) begin
			item.secs = 19'(corner_value(99) * 3600 + corner_value(59) * 60 + corner_value(59));
		end else begin
			item.secs = 19'($urandom);
		end
		item.mask = 3'($urandom_range(0, 7));
		return item;
	endfunction

	// Input driver: present the next queued item unless idling this cycle.
	always @(posedge clk) begin : drive_items
		time_item_t item;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				queue_digit_records(elapsed_seconds, highlight_mask);
				items_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (time_queue.size() > 0 && (no_gaps || $urandom_range(0, 99) >= 25)) begin
					item = time_queue.pop_front();
					in_valid <= 1'b1;
					elapsed_seconds <= item.secs;
					highlight_mask <= item.mask;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: check each accepted record against the oldest prediction.
	always @(posedge clk) begin : check_records
		digit_record_t exp_rec;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_records.size() == 0) begin
					err_count++;
					$display("%t: record with nothing predicted: col=%0d digit=%0d", $time,
						start_column, digit_value);
				end else begin
					exp_rec = pending_records.pop_front();
					records_checked++;
					if (exp_rec.column !== start_column || exp_rec.digit !== digit_value ||
						exp_rec.glyph !== glyph_bytes || exp_rec.underline !== underline_on ||
						exp_rec.last !== last_record) begin
						err_count++;
						$display("%t: record mismatch: expected col=%0d digit=%0d glyph=%h ul=%b last=%b",
							$time, exp_rec.column, exp_rec.digit, exp_rec.glyph,
							exp_rec.underline, exp_rec.last);
						$display("%t:                    actual col=%0d digit=%0d glyph=%h ul=%b last=%b",
							$time, start_column, digit_value, glyph_bytes, underline_on, last_record);
					end
				end
			end
			out_stall <= !no_gaps && ($urandom_range(0, 99) < 25);
		end
	end

	// APB write: setup cycle, then access until pready.
	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Read the base column back and compare with the local copy.
	task automatic apb_read_check();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_BASE_COLUMN;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {25'd0, model_base}) begin
			err_count++;
			$display("%t: base column readback: expected %0d actual %0d", $time,
				model_base, prdata);
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Write a new base column with junk in the unused upper bits.
	task automatic set_base(input logic [6:0] value);
		apb_write(ADDR_BASE_COLUMN, {25'($urandom), value});
		model_base = value;
		settings_applied++;
		apb_read_check();
	endtask

	// Wait until every item is accepted and every record seen, then let the
	// pipeline settle.
	task automatic wait_drained();
		do @(negedge clk);
		while (time_queue.size() != 0 || in_valid || pending_records.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	function automatic time_item_t make_item(input int secs, input int mask);
		time_item_t item;
		item.secs = 19'(secs);
		item.mask = 3'(mask);
		return item;
	endfunction

	// Main sequence: reset, directed items, then random phases at several bases.
	initial begin : stimulus
		int         phase;
		logic [6:0] next_base;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		apb_read_check();

		// Directed: zero, saturation point and beyond, field rollovers, all masks.
		time_queue.push_back(make_item(0, 0));
		time_queue.push_back(make_item(359999, 7));
		time_queue.push_back(make_item(360000, 5));
		time_queue.push_back(make_item(524287, 2));
		time_queue.push_back(make_item(1, 1));
		time_queue.push_back(make_item(9, 2));
		time_queue.push_back(make_item(10, 4));
		time_queue.push_back(make_item(59, 3));
		time_queue.push_back(make_item(60, 6));
		time_queue.push_back(make_item(599, 0));
		time_queue.push_back(make_item(600, 7));
		time_queue.push_back(make_item(3599, 1));
		time_queue.push_back(make_item(3600, 2));
		time_queue.push_back(make_item(35999, 4));
		time_queue.push_back(make_item(36000, 3));
		time_queue.push_back(make_item(86399, 5));
		time_queue.push_back(make_item(359940, 6));
		time_queue.push_back(make_item(123456, 7));
		time_queue.push_back(make_item(262144, 1));
		time_queue.push_back(make_item(131071, 6));
		time_queue.push_back(make_item(45296, 3));
		wait_drained();

		// Random phases; the column-underflow base also runs without any idling.
		for (phase = 0; phase < 7; phase++) begin
			case (phase)
				0:       next_base = 7'd120;
				1:       next_base = 7'd50;
				2:       next_base = 7'd0;
				3:       next_base = 7'd127;
				default: next_base = 7'($urandom_range(0, 127));
			endcase
			if (phase == 2) begin
				// A write outside the register map must leave the base alone.
				apb_write(ADDR_UNMAPPED, $urandom);
				apb_read_check();
			end
			set_base(next_base);
			no_gaps = (phase == 2);
			repeat (72) time_queue.push_back(random_time());
			wait_drained();
			no_gaps = 1'b0;
		end

		if (pending_records.size() != 0) begin
			err_count++;
			$display("%t: %0d predicted records never arrived", $time, pending_records.size());
		end
		$display("Covered %0d time items and %0d digit records over %0d base column settings.",
			items_accepted, records_checked, settings_applied + 1);
		if (err_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Watchdog.
	initial begin : watchdog
		#2000000;
		$display("%t: timeout", $time);
		$display("end of test: mismatches");
		$finish;
	end

endmodule
